// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is held
`define HPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// implication form: antecedent holds, consequent must hold in the same cycle
`define HPQ_ASSERT_IMPL(label, ante, cons, msg) \
	`HPQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/hpq_pkg.sv =====
package hpq_pkg;

	// default heap depth
	localparam int unsigned CAPACITY_DEF = 1024;

	// field widths
	localparam int unsigned KEY_W      = 32;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CNT_OUT_W  = 11;
	localparam int unsigned IN_DATA_W  = 2 * KEY_W;
	localparam int unsigned OUT_USED_W = 2 * KEY_W + STATUS_W + CNT_OUT_W;
	localparam int unsigned OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

	// flips both sign bits so an unsigned compare orders signed keys
	localparam logic [2*KEY_W-1:0] KEY_BIAS = 64'h8000_0000_8000_0000;

	// one heap entry, priority in the high half
	typedef struct packed {
		logic signed [KEY_W-1:0] pri;
		logic signed [KEY_W-1:0] tie;
	} entry_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_POP    = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

// ===== rtl/hpq_cmp.sv =====
module hpq_cmp (
	input  hpq_pkg::entry_t a,
	input  hpq_pkg::entry_t b,
	output logic            lt
);
	import hpq_pkg::*;

	logic [2*KEY_W-1:0] a_bias;
	logic [2*KEY_W-1:0] b_bias;

	// priority then tiebreak, both signed, as one biased unsigned compare
	assign a_bias = a ^ KEY_BIAS;
	assign b_bias = b ^ KEY_BIAS;
	assign lt     = a_bias < b_bias;

endmodule

// ===== rtl/binary_min_heap_priority_queue_core.sv =====
// binary min-heap priority queue
// input beat: tuser = command (0 insert, 1 pop), tdata = priority then tiebreak.
// output beat: one per command, tdata = popped priority, popped tiebreak, status
// (0 ok, 1 full, 2 empty) and the entry count after the command.
// entries live in an on-chip ram with one write port and two read ports; a single
// 64-bit comparator is reused for every step of a sift.
// insert: the new entry climbs toward the root with one read, then one compare and
// one write per level, until it stops below a smaller parent or reaches the root.
// pop: the last entry moves to the root and sinks toward a leaf; per level it reads
// both children, picks the smaller, compares it with the entry and writes;
// a pop that leaves the heap empty skips the sift.
// refused commands (insert when full, pop when empty) go straight to the result.
// the block takes one command at a time; s_axis_tready is high only while idle, so
// the next command can be taken from the cycle after the previous result is loaded.
// a finished result sits in the output register, so the next command can be
// accepted while it waits; a stalled receiver holds the following result in the
// sequencer until the output register frees up.
// reset empties the heap at once: no clearing pass, ram contents are not touched.
module binary_min_heap_priority_queue_core #(
	parameter int unsigned CAPACITY = hpq_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [31:0] priority_req, [63:32] tiebreak
	input  logic [hpq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] cmd
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [31:0] out_priority, [63:32] out_tiebreak, [65:64] status,
	// [76:66] entry_count, [79:77] zero
	output logic [hpq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import hpq_pkg::*;

	`include "assert_macros.svh"

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = AW + 2;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_UP_RD  = 9'b000000010,
		S_UP_CMP = 9'b000000100,
		S_POP_LD = 9'b000001000,
		S_DN_RD  = 9'b000010000,
		S_DN_SEL = 9'b000100000,
		S_DN_CMP = 9'b001000000,
		S_DONE   = 9'b010000000,
		S_SPARE  = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      fill_q;
	logic               m_valid_q;

	entry_t             carry_q;
	entry_t             cand_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      cidx_q;
	entry_t             res_q;
	status_t            res_status_q;

	entry_t             out_entry_q;
	status_t            out_status_q;
	logic [CNT_OUT_W-1:0] out_cnt_q;

	entry_t             heap_mem_q [CAPACITY];
	entry_t             rd_a_q;
	entry_t             rd_b_q;

	logic               in_acc;
	cmd_t               cmd;
	entry_t             in_entry;
	logic [CW-1:0]      fill_m1;
	logic [AW-1:0]      pos_m1;
	logic [AW-1:0]      parent;
	logic [XW-1:0]      left_x;
	logic [XW-1:0]      right_x;
	logic [XW-1:0]      fill_x;
	logic               left_ok;
	logic               right_ok;
	logic               out_free;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;

	logic [AW-1:0]      ra_c;
	logic [AW-1:0]      rb_c;
	logic               we_c;
	logic [AW-1:0]      wa_c;
	entry_t             wd_c;
	entry_t             cmp_a;
	entry_t             cmp_b;
	logic               lt;

	// input unpacking and index arithmetic
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign cmd      = cmd_t'(s_axis_tuser);
	assign in_entry = '{pri: s_axis_tdata[KEY_W-1:0], tie: s_axis_tdata[2*KEY_W-1:KEY_W]};
	assign fill_m1  = fill_q - CW'(1);
	assign pos_m1   = pos_q - AW'(1);
	assign parent   = pos_m1 >> 1;
	assign left_x   = {1'b0, pos_q, 1'b1};
	assign right_x  = left_x + XW'(1);
	assign fill_x   = XW'(fill_q);
	assign left_ok  = left_x < fill_x;
	assign right_ok = right_x < fill_x;
	assign out_free = !m_valid_q || m_axis_tready;
	assign cnt_ext  = {{CNT_OUT_W{1'b0}}, fill_q};

	assign s_axis_tready = state_q == S_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_cnt_q, out_status_q,
		out_entry_q.tie, out_entry_q.pri};

	// shared comparator
	hpq_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (lt)
	);

	// operand select, ram addresses and ram write per step
	always_comb begin
		cmp_a = carry_q;
		cmp_b = rd_a_q;
		ra_c  = '0;
		rb_c  = fill_m1[AW-1:0];
		we_c  = 1'b0;
		wa_c  = pos_q;
		wd_c  = carry_q;
		unique case (state_q)
			S_UP_RD: begin
				ra_c = parent;
				we_c = pos_q == '0;
			end
			S_UP_CMP: begin
				we_c = 1'b1;
				wd_c = lt ? rd_a_q : carry_q;
			end
			S_DN_RD: begin
				ra_c = left_x[AW-1:0];
				rb_c = right_x[AW-1:0];
				we_c = !left_ok;
			end
			S_DN_SEL: begin
				cmp_a = rd_b_q;
				cmp_b = rd_a_q;
			end
			S_DN_CMP: begin
				cmp_a = cand_q;
				cmp_b = carry_q;
				we_c  = 1'b1;
				wd_c  = lt ? cand_q : carry_q;
			end
			S_IDLE, S_POP_LD, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// heap ram, registered reads
	always_ff @(posedge clk) begin
		if (we_c) begin
			heap_mem_q[wa_c] <= wd_c;
		end
		rd_a_q <= heap_mem_q[ra_c];
		rd_b_q <= heap_mem_q[rb_c];
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// output register load and drain
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cmd == CMD_INSERT) begin
							if (fill_q == CW'(CAPACITY)) begin
								state_q <= S_DONE;
							end else begin
								fill_q  <= fill_q + CW'(1);
								state_q <= S_UP_RD;
							end
						end else begin
							if (fill_q == '0) begin
								state_q <= S_DONE;
							end else begin
								fill_q  <= fill_m1;
								state_q <= S_POP_LD;
							end
						end
					end
				end
				S_UP_RD: begin
					state_q <= (pos_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= lt ? S_UP_RD : S_DONE;
				end
				S_POP_LD: begin
					state_q <= (fill_q == '0) ? S_DONE : S_DN_RD;
				end
				S_DN_RD: begin
					state_q <= left_ok ? S_DN_SEL : S_DONE;
				end
				S_DN_SEL: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					state_q <= lt ? S_DN_RD : S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sift datapath and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				carry_q <= in_entry;
				pos_q   <= fill_q[AW-1:0];
				res_q   <= '0;
				if (cmd == CMD_INSERT && fill_q == CW'(CAPACITY)) begin
					res_status_q <= ST_FULL;
				end else if (cmd == CMD_POP && fill_q == '0) begin
					res_status_q <= ST_EMPTY;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_UP_CMP: begin
				if (lt) begin
					pos_q <= parent;
				end
			end
			S_POP_LD: begin
				res_q   <= rd_a_q;
				carry_q <= rd_b_q;
				pos_q   <= '0;
			end
			S_DN_SEL: begin
				if (right_ok && lt) begin
					cand_q <= rd_b_q;
					cidx_q <= right_x[AW-1:0];
				end else begin
					cand_q <= rd_a_q;
					cidx_q <= left_x[AW-1:0];
				end
			end
			S_DN_CMP: begin
				if (lt) begin
					pos_q <= cidx_q;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_entry_q  <= res_q;
					out_status_q <= res_status_q;
					out_cnt_q    <= cnt_ext[CNT_OUT_W-1:0];
				end
			end
			S_UP_RD, S_DN_RD: begin
			end
			default: begin
			end
		endcase
	end

	// checks
	`HPQ_ASSERT(a_fill_bound, fill_q <= CW'(CAPACITY), "fill count above capacity")
	`HPQ_ASSERT_IMPL(a_wr_in_heap, we_c, CW'(wa_c) < fill_q, "ram write outside held entries")
	`HPQ_ASSERT_IMPL(a_out_from_done, $rose(m_valid_q), $past(state_q == S_DONE),
		"result loaded outside done step")
	`HPQ_ASSERT_IMPL(a_empty_count, m_valid_q && out_status_q == ST_EMPTY, out_cnt_q == '0,
		"empty status with nonzero count")

endmodule
